FILE: rtl/core/wtnf_pkg.sv
// ----------------------------------------------------------------------------
// wtnf_pkg: shared types and constants for the weekly timer next-fire ranker
// Table geometry, packed entry and token layouts, sequencer states and the
// next-firing calculation used by every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package wtnf_pkg;

    localparam int MAX_TIMERS     = 16;
    localparam int SLOT_W         = $clog2(MAX_TIMERS);
    localparam int CNT_W          = $clog2(MAX_TIMERS + 1);
    localparam int MIN_W          = 14;
    localparam int TOD_W          = 11;
    localparam int DAY_MINUTES    = 24 * 60;
    localparam int WEEK_DAYS      = 7;

    // Field widths of the external channels.
    localparam int SLOT_FIELD_W   = 4;
    localparam int CNT_FIELD_W    = 5;
    localparam int RANK_FIELD_W   = 5;

    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_EVAL     = 1'b1;

    typedef struct packed {
        logic       enable;
        logic [6:0] days;
        logic [4:0] hour;
        logic [5:0] minute;
    } entry_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
    } now_t;

    // Token circulating around the ring during ranking.
    typedef struct packed {
        logic              valid;
        logic [MIN_W-1:0]  minutes;
        logic [SLOT_W-1:0] idx;
    } tok_t;

    typedef struct packed {
        logic             scheduled;
        logic [MIN_W-1:0] minutes;
        logic [CNT_W-1:0] rank;
    } res_t;

    typedef struct packed {
        logic wr;
        logic calc;
        logic shift;
    } ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_RANK,
        ST_EMIT
    } state_t;

    // Minutes until the timer next fires, saturated at zero.
    function automatic logic [MIN_W-1:0] fire_minutes(entry_t e, now_t n);
        logic [TOD_W-1:0]  tmin;
        logic [TOD_W-1:0]  nmin;
        logic signed [14:0] d;
        logic signed [14:0] v;
        logic [2:0]        w;
        logic [3:0]        sum;
        logic [2:0]        day;
        logic              found;
        tmin  = TOD_W'(e.hour) * TOD_W'(60) + TOD_W'(e.minute);
        nmin  = TOD_W'(n.hour) * TOD_W'(60) + TOD_W'(n.minute);
        d     = $signed({4'b0000, tmin}) - $signed({4'b0000, nmin});
        w     = (n.weekday == 3'd7) ? 3'd0 : n.weekday;
        v     = '0;
        found = 1'b0;
        if (e.days == 7'd0)
        begin
            v = d;
            if (v < 0)
            begin
                v = v + $signed(15'(DAY_MINUTES));
            end
        end
        else
        begin
            for (int k = 0; k <= WEEK_DAYS; k++)
            begin
                sum = {1'b0, w} + 4'(k);
                day = (sum >= 4'(WEEK_DAYS)) ? 3'(sum - 4'(WEEK_DAYS)) : sum[2:0];
                if (!found && e.days[day] && !(k == 0 && nmin > tmin))
                begin
                    v     = $signed(15'(k * DAY_MINUTES)) + d;
                    found = 1'b1;
                end
            end
        end
        if (v < 0)
        begin
            v = '0;
        end
        return v[MIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wtnf_if.sv
// ----------------------------------------------------------------------------
// wtnf_if: request and result channels of the timer ranker
// Valid/ready channels; one transfer when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface wtnf_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] slot;
    logic       timer_enable;
    logic [6:0] timer_days;
    logic [4:0] timer_hour;
    logic [5:0] timer_minute;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;

    modport source (
        output valid, command, slot, timer_enable, timer_days, timer_hour,
               timer_minute, now_weekday, now_hour, now_minute,
        input  ready
    );
    modport sink (
        input  valid, command, slot, timer_enable, timer_days, timer_hour,
               timer_minute, now_weekday, now_hour, now_minute,
        output ready
    );
endinterface

interface wtnf_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  result_slot;
    logic        scheduled;
    logic [13:0] minutes_until;
    logic [4:0]  rank;
    logic        last_result;

    modport source (
        output valid, result_slot, scheduled, minutes_until, rank, last_result,
        input  ready
    );
    modport sink (
        input  valid, result_slot, scheduled, minutes_until, rank, last_result,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/wtnf_cell.sv
// ----------------------------------------------------------------------------
// wtnf_cell: one timer slot of the ranking ring
// Holds the slot's entry and minutes; counts tokens that order ahead of it.
// ----------------------------------------------------------------------------
`default_nettype none

module wtnf_cell (
    input  logic                        clk,
    input  wtnf_pkg::ctrl_t             ctrl,
    input  logic                        wr_hit,
    input  wtnf_pkg::entry_t            wr_entry,
    input  wtnf_pkg::now_t              now,
    input  logic [wtnf_pkg::CNT_W-1:0]  count,
    input  logic [wtnf_pkg::SLOT_W-1:0] cell_index,
    input  wtnf_pkg::tok_t              tok_in,
    output wtnf_pkg::tok_t              tok_out,
    output wtnf_pkg::res_t              res
);
    import wtnf_pkg::*;

    entry_t           entry_reg;
    logic [MIN_W-1:0] minutes_reg;
    tok_t             tok_reg;
    logic [CNT_W-1:0] beats_reg;
    logic [MIN_W-1:0] minutes_calc;
    logic             beat;

    assign minutes_calc = fire_minutes(entry_reg, now);

    // Token ahead of us: smaller minutes, or equal minutes and lower slot.
    assign beat = tok_reg.valid &&
                  ((tok_reg.minutes < minutes_reg) ||
                   (tok_reg.minutes == minutes_reg && tok_reg.idx < cell_index));

    always_ff @(posedge clk)
    begin
        if (ctrl.wr && wr_hit)
        begin
            entry_reg <= wr_entry;
        end
        if (ctrl.calc)
        begin
            minutes_reg     <= minutes_calc;
            tok_reg.valid   <= entry_reg.enable && (CNT_W'(cell_index) < count);
            tok_reg.minutes <= minutes_calc;
            tok_reg.idx     <= cell_index;
            beats_reg       <= '0;
        end
        else if (ctrl.shift)
        begin
            tok_reg <= tok_in;
            if (beat)
            begin
                beats_reg <= beats_reg + CNT_W'(1);
            end
        end
    end

    assign tok_out       = tok_reg;
    assign res.scheduled = entry_reg.enable;
    assign res.minutes   = entry_reg.enable ? minutes_reg : '0;
    assign res.rank      = entry_reg.enable ? (beats_reg + CNT_W'(1)) : '0;

endmodule

`default_nettype wire

FILE: rtl/core/weekly_timer_next_fire_ranker_unit.sv
// ----------------------------------------------------------------------------
// weekly_timer_next_fire_ranker_unit: weekly switching-timer next-fire ranker
// Timer table in a ring of cells; evaluates and ranks timers against now.
// ----------------------------------------------------------------------------
// A write request (command 0) stores one timer slot and produces no
// result; the request channel is ready again on the next cycle.
// An evaluate request (command 1) first computes every slot's minutes
// until next firing; then the slot tokens travel once around the ring of
// cells so each cell counts how many enabled, in-use timers fire before
// it (ties go to the lower slot). Results then leave in slot order, one
// per cycle when the sink is ready. No request is taken from an accepted
// evaluate until its last result is loaded into the output register.
// timers_in_use above 16 counts as 16; with zero slots in use an
// evaluation returns nothing. Reading a slot that was never written
// gives undefined fields.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_timer_next_fire_ranker_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [wtnf_pkg::CNT_FIELD_W-1:0] cfg_wr_data,
    wtnf_req_if.sink                         request,
    wtnf_res_if.source                       result
);
    import wtnf_pkg::*;

    // Control registers
    state_t                 state_reg,  state_next;
    logic [CNT_FIELD_W-1:0] timers_in_use_reg;
    logic [SLOT_W-1:0]      rank_cnt_reg;
    logic [CNT_W-1:0]       emit_idx_reg;
    logic                   out_valid_reg;

    // Payload registers
    now_t                   now_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic                   out_sched_reg;
    logic [MIN_W-1:0]       out_min_reg;
    logic [CNT_W-1:0]       out_rank_reg;
    logic                   out_last_reg;

    ctrl_t                  ctrl;
    logic                   load_out;
    logic                   emit_last;
    logic [CNT_W-1:0]       count;
    entry_t                 wr_entry;
    logic [MAX_TIMERS-1:0]  wr_hit;
    tok_t                   tok [MAX_TIMERS];
    res_t                   cell_res [MAX_TIMERS];
    res_t                   sel_res;

    // Saturate the slot count to the table size
    assign count = (timers_in_use_reg > CNT_FIELD_W'(MAX_TIMERS)) ?
                   CNT_W'(MAX_TIMERS) : CNT_W'(timers_in_use_reg);

    assign wr_entry.enable = request.timer_enable;
    assign wr_entry.days   = request.timer_days;
    assign wr_entry.hour   = request.timer_hour;
    assign wr_entry.minute = request.timer_minute;

    assign emit_last = (emit_idx_reg + CNT_W'(1)) == count;
    assign sel_res   = cell_res[emit_idx_reg[SLOT_W-1:0]];

    // Ring of cells: each cell takes its neighbor's token every rank cycle
    for (genvar i = 0; i < MAX_TIMERS; i++)
    begin : g_cell
        assign wr_hit[i] = (32'(request.slot) == i);

        wtnf_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .wr_hit     (wr_hit[i]),
            .wr_entry   (wr_entry),
            .now        (now_reg),
            .count      (count),
            .cell_index (SLOT_W'(i)),
            .tok_in     (tok[(i + 1) % MAX_TIMERS]),
            .tok_out    (tok[i]),
            .res        (cell_res[i])
        );
    end

    // Sequencer: next state and strobes
    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        load_out      = 1'b0;
        request.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    if (request.command == CMD_WRITE)
                    begin
                        ctrl.wr = 1'b1;
                    end
                    else if (count != '0)
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                ctrl.calc  = 1'b1;
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                ctrl.shift = 1'b1;
                if (rank_cnt_reg == SLOT_W'(MAX_TIMERS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Refill the output register when empty or being drained
                if (!out_valid_reg || result.ready)
                begin
                    load_out = 1'b1;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            timers_in_use_reg <= '0;
            rank_cnt_reg      <= '0;
            emit_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                timers_in_use_reg <= cfg_wr_data;
            end
            if (ctrl.calc)
            begin
                rank_cnt_reg <= '0;
                emit_idx_reg <= '0;
            end
            else
            begin
                if (ctrl.shift)
                begin
                    rank_cnt_reg <= rank_cnt_reg + SLOT_W'(1);
                end
                if (load_out)
                begin
                    emit_idx_reg <= emit_idx_reg + CNT_W'(1);
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload capture: current time on an evaluate transfer, result on load
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready && request.command == CMD_EVAL)
        begin
            now_reg.weekday <= request.now_weekday;
            now_reg.hour    <= request.now_hour;
            now_reg.minute  <= request.now_minute;
        end
        if (load_out)
        begin
            out_slot_reg  <= emit_idx_reg[SLOT_W-1:0];
            out_sched_reg <= sel_res.scheduled;
            out_min_reg   <= sel_res.minutes;
            out_rank_reg  <= sel_res.rank;
            out_last_reg  <= emit_last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_slot   = SLOT_FIELD_W'(out_slot_reg);
    assign result.scheduled     = out_sched_reg;
    assign result.minutes_until = out_min_reg;
    assign result.rank          = RANK_FIELD_W'(out_rank_reg);
    assign result.last_result   = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wtnf_checker.sv
// ----------------------------------------------------------------------------
// wtnf_checker: port-level checks for the timer ranker
// Watches the request and result ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module wtnf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        req_command,
    input logic        res_valid,
    input logic        res_ready,
    input logic [3:0]  res_slot,
    input logic        res_scheduled,
    input logic [13:0] res_minutes,
    input logic [4:0]  res_rank,
    input logic        res_last
);
    import wtnf_pkg::*;

    // A stalled result keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_slot) &&
        $stable(res_scheduled) && $stable(res_rank) && $stable(res_minutes) &&
        $stable(res_last))
        else $error("result changed while stalled");

    // Write transfers never stall the request channel.
    a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_command == CMD_WRITE |=> req_ready)
        else $error("request stalled after a write");

    // Mid-evaluation results follow back to back in slot order.
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=>
        res_valid && res_slot == 4'($past(res_slot) + 4'd1))
        else $error("result slot order broken");

    // No new request while an evaluation still has results to send.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !req_ready)
        else $error("request accepted during an evaluation");

endmodule

bind weekly_timer_next_fire_ranker_unit wtnf_checker u_wtnf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .req_command   (request.command),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_slot      (result.result_slot),
    .res_scheduled (result.scheduled),
    .res_minutes   (result.minutes_until),
    .res_rank      (result.rank),
    .res_last      (result.last_result)
);

`default_nettype wire

FILE: tb/wtnf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtnf_scoreboard: result predictor and scoreboard for the timer ranker
// Mirrors the timer table and the slots-in-use register from the observed
// transfers, predicts every result of an evaluation and checks the results
// in order.
// ----------------------------------------------------------------------------

module wtnf_scoreboard (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [wtnf_pkg::CNT_FIELD_W-1:0] cfg_wr_data,
    wtnf_req_if                              request,
    wtnf_res_if                              result,
    output int                               errors,
    output int                               pending
);
    import wtnf_pkg::*;

    typedef struct packed {
        logic [3:0]  slot;
        logic        scheduled;
        logic [13:0] minutes;
        logic [4:0]  rank;
        logic        last;
    } firing_t;

    entry_t             timer_copy [MAX_TIMERS];
    logic [CNT_FIELD_W-1:0] slots_in_use;
    firing_t            firing_q [$];

    // Minutes to the next firing of one timer, clamped at zero.
    function automatic logic [13:0] minutes_to_fire(entry_t e, logic [2:0] wd,
                                                    logic [4:0] hr, logic [5:0] mn);
        int  t_min;
        int  n_min;
        int  diff;
        int  val;
        int  day;
        bit  hit;
        t_min = int'(e.hour) * 60 + int'(e.minute);
        n_min = int'(hr) * 60 + int'(mn);
        diff  = t_min - n_min;
        val   = 0;
        hit   = 1'b0;
        if (e.days == 7'd0)
        begin
            val = (diff < 0) ? diff + DAY_MINUTES : diff;
        end
        else
        begin
            for (int n = 0; n <= WEEK_DAYS; n++)
            begin
                day = (int'(wd) + n) % WEEK_DAYS;
                if (!hit && e.days[day] && !(n == 0 && n_min > t_min))
                begin
                    val = n * DAY_MINUTES + diff;
                    hit = 1'b1;
                end
            end
        end
        if (val < 0)
        begin
            val = 0;
        end
        return 14'(val);
    endfunction

    // Predict the full result list of one evaluation.
    task automatic rank_timers(logic [2:0] wd, logic [4:0] hr, logic [5:0] mn);
        int          count;
        int          place;
        logic [13:0] mins [MAX_TIMERS];
        firing_t     f;
        count = (int'(slots_in_use) > MAX_TIMERS) ? MAX_TIMERS : int'(slots_in_use);
        for (int i = 0; i < count; i++)
        begin
            mins[i] = minutes_to_fire(timer_copy[i], wd, hr, mn);
        end
        for (int i = 0; i < count; i++)
        begin
            place = 0;
            if (timer_copy[i].enable)
            begin
                place = 1;
                for (int j = 0; j < count; j++)
                begin
                    if (j != i && timer_copy[j].enable &&
                        (mins[j] < mins[i] || (mins[j] == mins[i] && j < i)))
                    begin
                        place++;
                    end
                end
            end
            f.slot      = 4'(i);
            f.scheduled = timer_copy[i].enable;
            f.minutes   = timer_copy[i].enable ? mins[i] : 14'd0;
            f.rank      = 5'(place);
            f.last      = (i + 1 == count);
            firing_q.push_back(f);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        firing_t got;
        firing_t want;
        if (!rst_n)
        begin
            firing_q.delete();
            slots_in_use = '0;
            errors       = 0;
            pending     <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = {result.result_slot, result.scheduled, result.minutes_until,
                       result.rank, result.last_result};
                if (firing_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("MISMATCH: unexpected result slot %0d sched %0d min %0d rank %0d last %0d",
                                 got.slot, got.scheduled, got.minutes, got.rank, got.last);
                end
                else
                begin
                    want = firing_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("MISMATCH: slot %0d/%0d sched %0d/%0d min %0d/%0d rank %0d/%0d last %0d/%0d (exp/act)",
                                     want.slot, got.slot, want.scheduled, got.scheduled,
                                     want.minutes, got.minutes, want.rank, got.rank,
                                     want.last, got.last);
                    end
                end
            end
            if (cfg_wr_en)
            begin
                slots_in_use = cfg_wr_data;
            end
            if (request.valid && request.ready)
            begin
                if (request.command == CMD_WRITE)
                begin
                    timer_copy[request.slot] = '{enable: request.timer_enable,
                                                 days:   request.timer_days,
                                                 hour:   request.timer_hour,
                                                 minute: request.timer_minute};
                end
                else
                begin
                    rank_timers(request.now_weekday, request.now_hour, request.now_minute);
                end
            end
            pending <= firing_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the timer ranker testbench
// Drives write and evaluate requests and the slots-in-use register with
// random idling on both channels; the checker predicts and scores results.
// ----------------------------------------------------------------------------

module tb;
    import wtnf_pkg::*;

    // Generous run limit: covers each evaluation with up to 16 results that
    // may each stall, plus sender gaps and register pauses.
    localparam int LIMIT_CYCLES = 400000;
    // Settling time before a register write, after the results have drained.
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 100;

    typedef struct packed {
        logic       command;
        logic [3:0] slot;
        logic       timer_enable;
        logic [6:0] timer_days;
        logic [4:0] timer_hour;
        logic [5:0] timer_minute;
        logic [2:0] now_weekday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
    } req_item_t;

    localparam int REQ_W = $bits(req_item_t);

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CNT_FIELD_W-1:0] cfg_wr_data;
    int                     errors;
    int                     pending;
    int                     cycle_cnt = 0;
    bit                     tx_idle;

    wtnf_req_if req_ch ();
    wtnf_res_if res_ch ();

    weekly_timer_next_fire_ranker_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_ch),
        .result      (res_ch)
    );

    wtnf_scoreboard i_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_ch),
        .result      (res_ch),
        .errors      (errors),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item builders. Unused fields of each command carry random bits so
    // every input bit toggles; the block must ignore them.
    // ------------------------------------------------------------------
    function automatic req_item_t mk_write(int s, bit en, logic [6:0] days,
                                           logic [4:0] hr, logic [5:0] mn);
        req_item_t it;
        it              = req_item_t'(REQ_W'({$urandom, $urandom}));
        it.command      = CMD_WRITE;
        it.slot         = 4'(s);
        it.timer_enable = en;
        it.timer_days   = days;
        it.timer_hour   = hr;
        it.timer_minute = mn;
        return it;
    endfunction

    function automatic req_item_t mk_eval(logic [2:0] wd, logic [4:0] hr, logic [5:0] mn);
        req_item_t it;
        it             = req_item_t'(REQ_W'({$urandom, $urandom}));
        it.command     = CMD_EVAL;
        it.now_weekday = wd;
        it.now_hour    = hr;
        it.now_minute  = mn;
        return it;
    endfunction

    // Hours and minutes mostly in range, now and then at full field width.
    function automatic logic [4:0] rand_hour();
        return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 23));
    endfunction

    function automatic logic [5:0] rand_minute();
        return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 59));
    endfunction

    function automatic req_item_t rand_item();
        logic [6:0] days;
        if ($urandom_range(0, 9) < 4)
        begin
            return mk_eval(3'($urandom_range(0, 7)), rand_hour(), rand_minute());
        end
        case ($urandom_range(0, 7))
            0:       days = 7'd0;
            1:       days = 7'h7F;
            2:       days = 7'(1 << $urandom_range(0, 6));
            default: days = 7'($urandom_range(0, 127));
        endcase
        return mk_write($urandom_range(0, 15), 1'($urandom_range(0, 1)), days,
                        rand_hour(), rand_minute());
    endfunction

    // Directed table: one-shots, every-day, single days, disabled slots,
    // ties, and out-of-range hour/minute values.
    function automatic req_item_t directed_write(int s);
        case (s)
            0:       return mk_write(s, 1'b1, 7'h00, 5'd0,  6'd0);
            1:       return mk_write(s, 1'b1, 7'h7F, 5'd23, 6'd59);
            2:       return mk_write(s, 1'b0, 7'h7F, 5'd12, 6'd0);
            3:       return mk_write(s, 1'b1, 7'h01, 5'd6,  6'd30);
            4:       return mk_write(s, 1'b1, 7'h40, 5'd31, 6'd63);
            5:       return mk_write(s, 1'b1, 7'h00, 5'd31, 6'd63);
            6:       return mk_write(s, 1'b1, 7'h7F, 5'd23, 6'd59);
            7:       return mk_write(s, 1'b1, 7'h2A, 5'd12, 6'd30);
            8:       return mk_write(s, 1'b0, 7'h00, 5'd0,  6'd0);
            9:       return mk_write(s, 1'b1, 7'h08, 5'd0,  6'd0);
            10:      return mk_write(s, 1'b1, 7'h00, 5'd12, 6'd30);
            11:      return mk_write(s, 1'b1, 7'h55, 5'd18, 6'd15);
            12:      return mk_write(s, 1'b1, 7'h7F, 5'd0,  6'd0);
            13:      return mk_write(s, 1'b1, 7'h10, 5'd23, 6'd59);
            14:      return mk_write(s, 1'b0, 7'h7F, 5'd31, 6'd63);
            default: return mk_write(s, 1'b1, 7'h01, 5'd12, 6'd30);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side. valid is only lowered when a gap follows, so it never
    // drops and rises in the same step.
    // ------------------------------------------------------------------
    task automatic send_req(input req_item_t it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= it.command;
        req_ch.slot         <= it.slot;
        req_ch.timer_enable <= it.timer_enable;
        req_ch.timer_days   <= it.timer_days;
        req_ch.timer_hour   <= it.timer_hour;
        req_ch.timer_minute <= it.timer_minute;
        req_ch.now_weekday  <= it.now_weekday;
        req_ch.now_hour     <= it.now_hour;
        req_ch.now_minute   <= it.now_minute;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has arrived.
    // The first edge lets the checker's count catch up with the last transfer.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Register write with the block idle; the settle time covers any
    // write request or empty evaluation still in flight.
    task automatic write_slots_in_use(input logic [CNT_FIELD_W-1:0] val);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: a random stall before each transfer, in stretches that
    // are randomly either idling or full throughput.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        int left;
        bit rx_idle;
        left    = 0;
        rx_idle = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (left == 0)
            begin
                rx_idle = ($urandom_range(0, 2) != 0);
                left    = $urandom_range(10, 40);
            end
            left--;
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin
        int                     sent;
        int                     n_items;
        int                     phase;
        logic [CNT_FIELD_W-1:0] cfg_val;

        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= CMD_WRITE;
        req_ch.slot         <= '0;
        req_ch.timer_enable <= 1'b0;
        req_ch.timer_days   <= '0;
        req_ch.timer_hour   <= '0;
        req_ch.timer_minute <= '0;
        req_ch.now_weekday  <= '0;
        req_ch.now_hour     <= '0;
        req_ch.now_minute   <= '0;
        tx_idle = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Zero slots in use right after reset: the
        // evaluation returns nothing and reads no slot.
        send_req(mk_eval(3'd2, 5'd10, 6'd15));
        for (int s = 0; s < MAX_TIMERS; s++)
        begin
            send_req(directed_write(s));
        end
        write_slots_in_use(CNT_FIELD_W'(MAX_TIMERS));
        send_req(mk_eval(3'd0, 5'd0,  6'd0));
        // Weekday 7 wraps to Sunday; 31:63 drives negative differences
        // that must clamp to zero.
        send_req(mk_eval(3'd7, 5'd31, 6'd63));
        send_req(mk_eval(3'd6, 5'd23, 6'd59));
        send_req(mk_eval(3'd3, 5'd12, 6'd30));
        // Counts past the table size saturate to the full table.
        write_slots_in_use(5'd31);
        send_req(mk_eval(3'd0, 5'd6, 6'd30));
        write_slots_in_use(5'd1);
        send_req(mk_eval(3'd5, 5'd0, 6'd0));

        // Random part: phases with a fresh register value each. The first
        // four phases pin the extremes, later ones draw freely.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:       cfg_val = 5'd0;
                1:       cfg_val = 5'd1;
                2:       cfg_val = CNT_FIELD_W'(MAX_TIMERS);
                3:       cfg_val = 5'd31;
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       cfg_val = 5'd0;
                        1:       cfg_val = 5'd1;
                        2:       cfg_val = CNT_FIELD_W'(MAX_TIMERS);
                        default: cfg_val = 5'($urandom_range(0, 31));
                    endcase
                end
            endcase
            write_slots_in_use(cfg_val);
            tx_idle = ($urandom_range(0, 2) != 0);
            n_items = $urandom_range(6, 14);
            for (int k = 0; k < n_items; k++)
            begin
                // Hold the sender until the block has emptied once.
                if (phase == 2 && k == n_items / 2)
                begin
                    drain_results();
                end
                send_req(rand_item());
                sent++;
            end
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
